[src/lpgc_pkg.sv]
// shared types and constants for the linear probe group count table
package lpgc_pkg;

   localparam int TABLE_SIZE = 1024;
   localparam int LANES      = 16;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int LANE_W     = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int KEY_W      = 32;
   localparam int CNT_W      = 32;

   localparam logic [KEY_W-1:0] VACANT_KEY = '0;

   localparam logic OP_COUNT  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_KEY_ZERO = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_CHECK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] key;
      logic [9:0]  home_slot;
      logic        batch_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] count;
      logic        batch_last;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0] addr;
      logic             wr_en;
      logic [KEY_W-1:0] wr_key;
      logic [CNT_W-1:0] wr_count;
   } mem_req_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] count;
   } mem_rsp_type;

endpackage

[src/lpgc_store.sv]
// key and count memories with registered read
module lpgc_store import lpgc_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output mem_rsp_type mem_rsp
);

   logic [KEY_W-1:0] key_mem [TABLE_SIZE];
   logic [CNT_W-1:0] count_mem [TABLE_SIZE];
   logic [KEY_W-1:0] rd_key_ff;
   logic [CNT_W-1:0] rd_count_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         key_mem[mem_req.addr]   <= mem_req.wr_key;
         count_mem[mem_req.addr] <= mem_req.wr_count;
      end
      rd_key_ff   <= key_mem[mem_req.addr];
      rd_count_ff <= count_mem[mem_req.addr];
   end

   assign mem_rsp.key   = rd_key_ff;
   assign mem_rsp.count = rd_count_ff;

endmodule

[src/linear_probe_group_count_table_unit.sv]
// top level: probe sequencer over the slot store
// a key of zero is answered without probing; otherwise each slot probed passes a read and a check state
// throughput: one transaction at a time, busy is high until its result strobe
// probing reads one slot at a time through the single store port
// after reset a clearing pass over all 1024 slots empties the store, busy stays high
// the result is shown for one cycle on rsp_valid, the receiver cannot stall
module linear_probe_group_count_table_unit import lpgc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LANE_W-1:0] lane_ff, lane_in;
   logic             wrapped_ff, wrapped_in;
   logic             empty_found_ff, empty_found_in;
   logic [IDX_W-1:0] empty_idx_ff, empty_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   mem_req_type      mem_req;
   mem_rsp_type      mem_rsp;

   logic             accept;
   logic             hit;
   logic             empty_here;
   logic             win_end;
   logic             last_slot;
   logic             have_empty;
   logic [IDX_W-1:0] ins_idx;
   logic [CNT_W-1:0] inc_count;

   lpgc_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign hit        = (mem_rsp.key == req_ff.key);
   assign empty_here = (mem_rsp.key == VACANT_KEY);
   assign last_slot  = (idx_ff == IDX_W'(TABLE_SIZE - 1));
   assign win_end    = (lane_ff == LANE_W'(LANES - 1)) || last_slot;
   assign have_empty = empty_found_ff || empty_here;
   assign ins_idx    = empty_found_ff ? empty_idx_ff : idx_ff;
   assign inc_count  = mem_rsp.count + CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (last_slot) state_in = S_IDLE;
         S_IDLE: begin
            if (start) state_in = (req_data.key == VACANT_KEY) ? S_RESP : S_READ;
         end
         S_READ:  state_in = S_CHECK;
         S_CHECK: begin
            if (req_ff.operation == OP_LOOKUP) begin
               if (hit || empty_here) state_in = S_RESP;
               else if (win_end && last_slot && wrapped_ff) state_in = S_RESP;
               else state_in = S_READ;
            end else begin
               if (hit) state_in = S_RESP;
               else if (win_end && have_empty) state_in = S_RESP;
               else if (win_end && last_slot && wrapped_ff) state_in = S_RESP;
               else state_in = S_READ;
            end
         end
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      req_in         = req_ff;
      idx_in         = idx_ff;
      lane_in        = lane_ff;
      wrapped_in     = wrapped_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      mem_req.addr     = idx_ff;
      mem_req.wr_en    = 1'b0;
      mem_req.wr_key   = req_ff.key;
      mem_req.wr_count = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_req.wr_en  = 1'b1;
            mem_req.wr_key = VACANT_KEY;
            idx_in         = idx_ff + IDX_W'(1);
         end
         S_IDLE: begin
            if (accept) begin
               req_in         = req_data;
               idx_in         = req_data.home_slot[IDX_W-1:0];
               lane_in        = '0;
               wrapped_in     = 1'b0;
               empty_found_in = 1'b0;
               rsp_in.status     = ST_KEY_ZERO;
               rsp_in.count      = '0;
               rsp_in.batch_last = req_data.batch_end;
            end
         end
         S_READ: ;
         S_CHECK: begin
            rsp_in.status = ST_OK;
            if (req_ff.operation == OP_LOOKUP && (hit || empty_here)) begin
               rsp_in.count = mem_rsp.count;
            end else if (req_ff.operation == OP_COUNT && hit) begin
               mem_req.wr_en    = 1'b1;
               mem_req.wr_count = inc_count;
               rsp_in.count     = inc_count;
            end else if (req_ff.operation == OP_COUNT && win_end && have_empty) begin
               mem_req.addr     = ins_idx;
               mem_req.wr_en    = 1'b1;
               mem_req.wr_count = CNT_W'(1);
               rsp_in.count     = CNT_W'(1);
            end else begin
               if (empty_here && !empty_found_ff) begin
                  empty_found_in = 1'b1;
                  empty_idx_in   = idx_ff;
               end
               if (win_end) begin
                  lane_in        = '0;
                  empty_found_in = 1'b0;
                  if (last_slot) begin
                     if (wrapped_ff) begin
                        rsp_in.status = ST_FULL;
                        rsp_in.count  = '0;
                     end
                     idx_in     = '0;
                     wrapped_in = 1'b1;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end else begin
                  lane_in = lane_ff + LANE_W'(1);
                  idx_in  = idx_ff + IDX_W'(1);
               end
            end
         end
         S_RESP: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         idx_ff         <= '0;
         lane_ff        <= '0;
         wrapped_ff     <= 1'b0;
         empty_found_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         lane_ff        <= lane_in;
         wrapped_ff     <= wrapped_in;
         empty_found_ff <= empty_found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_ff       <= req_in;
      empty_idx_ff <= empty_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
